// ===== hdl/sbsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the slab bitmap slot allocator.
// No dependencies; used by every module of the block.
package sbsa_pkg;

    localparam int SLOTS_PER_PAGE = 128;
    localparam int SLOT_W         = 7;
    localparam int PAGE_BYTES_LOG2 = 12;

    localparam logic [3:0] BLK_LOG2_MIN   = 4'd5;
    localparam logic [3:0] BLK_LOG2_MAX   = 4'd12;
    localparam logic [3:0] BLK_LOG2_RESET = 4'd5;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_TOGGLE = 2'd1;
    localparam logic [1:0] OP_ADD    = 2'd2;
    localparam logic [1:0] OP_BAD    = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    typedef logic [SLOTS_PER_PAGE-1:0] bitmap_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  page_index;
        logic [11:0] byte_offset;
    } req_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] result_page;
        logic [6:0] result_slot;
    } rsp_item_t;

endpackage

// ===== hdl/sbsa_bitmap_ram.sv =====
`timescale 1ns / 1ps
// Page bitmap store: one write port, one read port, registered read data.
// Depends on sbsa_pkg for the bitmap type.
module sbsa_bitmap_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  sbsa_pkg::bitmap_t wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output sbsa_pkg::bitmap_t rdata
);

    sbsa_pkg::bitmap_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/sbsa_ffz.sv =====
`timescale 1ns / 1ps
// Find-first-zero over one page bitmap, limited to the active slot count.
// Depends on sbsa_pkg for the bitmap type and slot width.
module sbsa_ffz (
    input  sbsa_pkg::bitmap_t                 bitmap,
    input  logic [3:0]                        blk_log2,
    output logic                              found,
    output logic [sbsa_pkg::SLOT_W-1:0]       slot
);

    logic [7:0] limit;

    always_comb
    begin
        limit = 8'd1 << (4'd12 - blk_log2);
        found = 1'b0;
        slot  = '0;
        for (int i = sbsa_pkg::SLOTS_PER_PAGE - 1; i >= 0; i--)
        begin
            if (!bitmap[i] && (8'(i) < limit))
            begin
                found = 1'b1;
                slot  = sbsa_pkg::SLOT_W'(i);
            end
        end
    end

endmodule

// ===== hdl/slab_bitmap_slot_allocator.sv =====
`timescale 1ns / 1ps
// Top level of the slab bitmap slot allocator: control sequencer and result register.
// Depends on sbsa_pkg, sbsa_bitmap_ram and sbsa_ffz.
//
// Usage:
//   Requests arrive on req_valid / req_stall / req_item; a transfer happens when
//   req_valid is high and req_stall is low. Each request gives exactly one response
//   on rsp_valid / rsp_stall / rsp_item, in request order.
//   cfg_we with cfg_wdata writes the block size (log2) register; write it only idle.
//   One request is in work at a time; the next is taken the cycle after the
//   previous response enters the output register. Toggle passes from transfer through
//   S_TOGGLE and S_PUSH to the output register; allocate scans pages in S_SCAN, since the
//   bitmap memory delivers one page per cycle through its single read port, up to
//   MAX_PAGES pages, then goes to S_PUSH. Add-page and rejected requests go straight to S_PUSH.
//   A response waits in the output register while rsp_stall is high; the next
//   request can be taken and worked on meanwhile, and its response waits in the
//   sequencer until the output register frees.
//   Reset empties the page list and sets the block size register to 5 (32 bytes);
//   bitmap memory contents are not cleared, as each page is written when added.
module slab_bitmap_slot_allocator #(
    parameter int MAX_PAGES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  sbsa_pkg::req_item_t req_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output sbsa_pkg::rsp_item_t rsp_item,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_wdata
);

    localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_TOGGLE = 2'd2;
    localparam logic [1:0] S_PUSH   = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            pages_reg, pages_next;
    logic [3:0]                  blk_reg;
    logic [3:0]                  blk_eff;
    logic [PAGE_W-1:0]           page_reg, page_next;
    logic [sbsa_pkg::SLOT_W-1:0] slot_reg, slot_next;
    sbsa_pkg::rsp_item_t         res_reg, res_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    sbsa_pkg::rsp_item_t         rsp_item_reg, rsp_item_next;

    logic                        mem_we;
    logic [PAGE_W-1:0]           mem_waddr;
    sbsa_pkg::bitmap_t           mem_wdata;
    logic                        mem_re;
    logic [PAGE_W-1:0]           mem_raddr;
    sbsa_pkg::bitmap_t           mem_rdata;

    logic                        ffz_found;
    logic [sbsa_pkg::SLOT_W-1:0] ffz_slot;
    logic                        req_xfer;
    logic                        out_free;

    sbsa_bitmap_ram #(
        .DEPTH (MAX_PAGES),
        .AW    (PAGE_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sbsa_ffz u_ffz (
        .bitmap   (mem_rdata),
        .blk_log2 (blk_eff),
        .found    (ffz_found),
        .slot     (ffz_slot)
    );

    always_comb
    begin
        if (blk_reg < sbsa_pkg::BLK_LOG2_MIN)
        begin
            blk_eff = sbsa_pkg::BLK_LOG2_MIN;
        end
        else if (blk_reg > sbsa_pkg::BLK_LOG2_MAX)
        begin
            blk_eff = sbsa_pkg::BLK_LOG2_MAX;
        end
        else
        begin
            blk_eff = blk_reg;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    always_comb
    begin
        state_next = state_reg;
        pages_next = pages_reg;
        page_next  = page_reg;
        slot_next  = slot_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = page_reg;
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = page_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    res_next   = '0;
                    state_next = S_PUSH;
                    case (req_item.opcode)
                        sbsa_pkg::OP_ALLOC:
                        begin
                            if (pages_reg == '0)
                            begin
                                res_next.status = sbsa_pkg::ST_NO_FREE;
                            end
                            else
                            begin
                                page_next  = '0;
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                state_next = S_SCAN;
                            end
                        end
                        sbsa_pkg::OP_TOGGLE:
                        begin
                            if (32'(req_item.page_index) >= 32'(pages_reg))
                            begin
                                res_next.status = sbsa_pkg::ST_BAD;
                            end
                            else
                            begin
                                page_next  = PAGE_W'(req_item.page_index);
                                slot_next  = sbsa_pkg::SLOT_W'(req_item.byte_offset >> blk_eff);
                                mem_re     = 1'b1;
                                mem_raddr  = PAGE_W'(req_item.page_index);
                                state_next = S_TOGGLE;
                            end
                        end
                        sbsa_pkg::OP_ADD:
                        begin
                            if (pages_reg == CNT_W'(MAX_PAGES))
                            begin
                                res_next.status = sbsa_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = PAGE_W'(pages_reg);
                                mem_wdata   = sbsa_pkg::bitmap_t'(1);
                                pages_next  = pages_reg + CNT_W'(1);
                                res_next.result_page = 4'(pages_reg);
                            end
                        end
                        default:
                        begin
                            res_next.status = sbsa_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (ffz_found)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = page_reg;
                    mem_wdata = mem_rdata | (sbsa_pkg::bitmap_t'(1) << ffz_slot);
                    res_next.status      = sbsa_pkg::ST_OK;
                    res_next.result_page = 4'(page_reg);
                    res_next.result_slot = ffz_slot;
                    state_next = S_PUSH;
                end
                else if ((CNT_W'(page_reg) + CNT_W'(1)) < pages_reg)
                begin
                    page_next = page_reg + PAGE_W'(1);
                    mem_re    = 1'b1;
                    mem_raddr = page_reg + PAGE_W'(1);
                end
                else
                begin
                    res_next.status = sbsa_pkg::ST_NO_FREE;
                    state_next      = S_PUSH;
                end
            end
            S_TOGGLE:
            begin
                mem_we    = 1'b1;
                mem_waddr = page_reg;
                mem_wdata = mem_rdata ^ (sbsa_pkg::bitmap_t'(1) << slot_reg);
                res_next.status      = sbsa_pkg::ST_OK;
                res_next.result_page = 4'(page_reg);
                res_next.result_slot = slot_reg;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;
        if ((state_reg == S_PUSH) && out_free)
        begin
            rsp_valid_next = 1'b1;
            rsp_item_next  = res_reg;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pages_reg     <= '0;
            blk_reg       <= sbsa_pkg::BLK_LOG2_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pages_reg     <= pages_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                blk_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg     <= page_next;
        slot_reg     <= slot_next;
        res_reg      <= res_next;
        rsp_item_reg <= rsp_item_next;
    end

    a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pages_reg) <= MAX_PAGES)
        else $error("page count beyond MAX_PAGES");

    a_pages_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pages_reg != $past(pages_reg)) |-> (pages_reg == $past(pages_reg) + CNT_W'(1)))
        else $error("page count moved by more than one");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNT_W'(page_reg) < pages_reg))
        else $error("scan beyond appended pages");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_item.status != sbsa_pkg::ST_OK))
            |-> ((rsp_item.result_page == '0) && (rsp_item.result_slot == '0)))
        else $error("failed response carries page or slot");

    a_add_write: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg == S_IDLE)) |=> (pages_reg == $past(pages_reg) + CNT_W'(1)))
        else $error("page write without page count advance");

endmodule

// ===== verif/slab_bitmap_slot_allocator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for slab_bitmap_slot_allocator: directed and random requests
// over many block sizes, checked against a slot occupancy model kept in the bench.
// Depends on sbsa_pkg and the slab_bitmap_slot_allocator RTL.
module slab_bitmap_slot_allocator_tb;

    localparam int MAX_PAGES  = 16;
    localparam int CYCLE_CAP  = 600000;
    localparam int HOLD_LEN   = 300;
    localparam int HOLD_AT    = 700;
    localparam int STEADY_LO  = 1200;
    localparam int STEADY_HI  = 1450;
    localparam int PHASE_LEN  = 160;
    localparam int SETTLE_CYC = MAX_PAGES + 4;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    sbsa_pkg::req_item_t req_item = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    sbsa_pkg::rsp_item_t rsp_item;
    logic                cfg_we = 1'b0;
    logic [3:0]          cfg_wdata = 4'd0;

    sbsa_pkg::req_item_t req_backlog[$];
    sbsa_pkg::rsp_item_t pending_results[$];
    int          reqs_queued = 0;
    int          reqs_taken = 0;
    int          rsps_seen = 0;
    int          mismatches = 0;
    int          cycle_cnt = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    logic        steady;

    logic [sbsa_pkg::SLOTS_PER_PAGE-1:0] slot_map [MAX_PAGES];
    int          pages_added = 0;
    logic [3:0]  blk_log2 = sbsa_pkg::BLK_LOG2_RESET;

    logic [3:0]  size_plan [12] = '{4'd15, 4'd9, 4'd0, 4'd12, 4'd7, 4'd11,
                                    4'd3, 4'd6, 4'd10, 4'd8, 4'd13, 4'd5};

    slab_bitmap_slot_allocator #(.MAX_PAGES(MAX_PAGES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    assign steady = (reqs_taken >= STEADY_LO) && (reqs_taken < STEADY_HI);

    function automatic sbsa_pkg::rsp_item_t predict_slot_result(
        input sbsa_pkg::req_item_t r);
        sbsa_pkg::rsp_item_t o;
        int unsigned eff;
        int unsigned nslots;
        int unsigned s;
        logic        found;
        o = '0;
        o.status = sbsa_pkg::ST_OK;
        found = 1'b0;
        if (blk_log2 < sbsa_pkg::BLK_LOG2_MIN)
            eff = 32'(sbsa_pkg::BLK_LOG2_MIN);
        else if (blk_log2 > sbsa_pkg::BLK_LOG2_MAX)
            eff = 32'(sbsa_pkg::BLK_LOG2_MAX);
        else
            eff = 32'(blk_log2);
        case (r.opcode)
            sbsa_pkg::OP_ALLOC:
            begin
                nslots = 1 << (sbsa_pkg::PAGE_BYTES_LOG2 - eff);
                for (int p = 0; p < pages_added && !found; p++)
                begin
                    for (int k = 0; k < nslots && !found; k++)
                    begin
                        if (!slot_map[p][k])
                        begin
                            slot_map[p][k] = 1'b1;
                            o.result_page = 4'(p);
                            o.result_slot = 7'(k);
                            found = 1'b1;
                        end
                    end
                end
                if (!found)
                    o.status = sbsa_pkg::ST_NO_FREE;
            end
            sbsa_pkg::OP_TOGGLE:
            begin
                if (int'(r.page_index) >= pages_added)
                    o.status = sbsa_pkg::ST_BAD;
                else
                begin
                    s = 32'(r.byte_offset >> eff);
                    slot_map[r.page_index][s] = ~slot_map[r.page_index][s];
                    o.result_page = r.page_index;
                    o.result_slot = 7'(s);
                end
            end
            sbsa_pkg::OP_ADD:
            begin
                if (pages_added >= MAX_PAGES)
                    o.status = sbsa_pkg::ST_FULL;
                else
                begin
                    slot_map[pages_added] = '0;
                    slot_map[pages_added][0] = 1'b1;
                    o.result_page = 4'(pages_added);
                    pages_added++;
                end
            end
            default:
                o.status = sbsa_pkg::ST_BAD;
        endcase
        return o;
    endfunction

    function automatic sbsa_pkg::req_item_t mk_req(input logic [1:0] op,
                                                   input logic [3:0] pg,
                                                   input logic [11:0] off);
        sbsa_pkg::req_item_t r;
        r.opcode = op;
        r.page_index = pg;
        r.byte_offset = off;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    endtask

    // hold the current transfer until taken, then idle or advance
    always @(posedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || !req_stall)
        begin
            if (!steady && $urandom_range(0, 99) < 16)
                req_valid <= 1'b0;
            else if (req_backlog.size() != 0)
            begin
                req_valid <= 1'b1;
                req_item <= req_backlog.pop_front();
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (cfg_we)
            blk_log2 = cfg_wdata;
        if (rst_n && req_valid && !req_stall)
        begin
            pending_results.push_back(predict_slot_result(req_item));
            reqs_taken <= reqs_taken + 1;
        end
    end

    always @(posedge clk)
    begin
        if (!hold_done && reqs_taken >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
        rsp_stall <= (hold_left != 0) || (!steady && $urandom_range(0, 99) < 16);

    always @(posedge clk)
    begin : rsp_check
        sbsa_pkg::rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: status %0d page %0d slot %0d at %0t",
                             rsp_item.status, rsp_item.result_page, rsp_item.result_slot,
                             $realtime);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_item.status !== want.status)
                    note_mismatch("status", int'(want.status), int'(rsp_item.status));
                if (rsp_item.result_page !== want.result_page)
                    note_mismatch("result_page", int'(want.result_page),
                                  int'(rsp_item.result_page));
                if (rsp_item.result_slot !== want.result_slot)
                    note_mismatch("result_slot", int'(want.result_slot),
                                  int'(rsp_item.result_slot));
            end
            rsps_seen <= rsps_seen + 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_CAP)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_req(input sbsa_pkg::req_item_t r);
        req_backlog.push_back(r);
        reqs_queued++;
    endtask

    task automatic settle();
        while (rsps_seen != reqs_queued)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_blk_size(input logic [3:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_random(input int count);
        int                  pick;
        sbsa_pkg::req_item_t r;
        for (int i = 0; i < count; i++)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < 50)
                r.opcode = sbsa_pkg::OP_ALLOC;
            else if (pick < 82)
                r.opcode = sbsa_pkg::OP_TOGGLE;
            else if (pick < 94)
                r.opcode = sbsa_pkg::OP_ADD;
            else
                r.opcode = sbsa_pkg::OP_BAD;
            if ($urandom_range(0, 1) == 0)
                r.page_index = 4'($urandom_range(0, 15));
            else
                r.page_index = 4'($urandom_range(0, 5));
            r.byte_offset = 12'($urandom_range(0, 4095));
            push_req(r);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        write_blk_size(sbsa_pkg::BLK_LOG2_RESET);

        push_req(mk_req(sbsa_pkg::OP_ALLOC, 4'd0, 12'd0));
        push_req(mk_req(sbsa_pkg::OP_TOGGLE, 4'd0, 12'd0));
        push_req(mk_req(sbsa_pkg::OP_BAD, 4'd15, 12'd4095));
        push_req(mk_req(sbsa_pkg::OP_ADD, 4'd0, 12'd0));
        push_req(mk_req(sbsa_pkg::OP_ALLOC, 4'd0, 12'd0));
        push_req(mk_req(sbsa_pkg::OP_ALLOC, 4'd15, 12'd4095));
        push_req(mk_req(sbsa_pkg::OP_TOGGLE, 4'd0, 12'd0));
        push_req(mk_req(sbsa_pkg::OP_ALLOC, 4'd0, 12'd0));
        push_req(mk_req(sbsa_pkg::OP_TOGGLE, 4'd0, 12'd4095));
        push_req(mk_req(sbsa_pkg::OP_TOGGLE, 4'd0, 12'd4095));
        push_req(mk_req(sbsa_pkg::OP_TOGGLE, 4'd1, 12'd0));
        push_req(mk_req(sbsa_pkg::OP_ADD, 4'd15, 12'd4095));
        push_req(mk_req(sbsa_pkg::OP_TOGGLE, 4'd1, 12'd32));
        push_req(mk_req(sbsa_pkg::OP_ALLOC, 4'd0, 12'd0));
        push_req(mk_req(sbsa_pkg::OP_TOGGLE, 4'd15, 12'd4095));
        push_req(mk_req(sbsa_pkg::OP_BAD, 4'd0, 12'd0));
        settle();

        foreach (size_plan[i])
        begin
            write_blk_size(size_plan[i]);
            push_random(PHASE_LEN);
            settle();
        end

        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sbsa_pkg.sv
hdl/sbsa_bitmap_ram.sv
hdl/sbsa_ffz.sv
hdl/slab_bitmap_slot_allocator.sv
verif/slab_bitmap_slot_allocator_tb.sv
